// ----- rtl/tssf_pkg.sv -----
`timescale 1ns / 1ps
// tssf_pkg: shared types, constants and digit tables for the time/speed
// seven-segment formatter. No dependencies.

package tssf_pkg;

    // panel codes carried on the op field
    localparam logic [1:0] PANEL_SET_TIME  = 2'd0;
    localparam logic [1:0] PANEL_REM_TIME  = 2'd1;
    localparam logic [1:0] PANEL_SET_SPEED = 2'd2;
    localparam logic [1:0] PANEL_ACT_SPEED = 2'd3;

    localparam int VALUE_W = 19;
    localparam int ADDR_W  = 6;
    localparam int NUM_DIG = 4;

    localparam logic [VALUE_W-1:0] TIME_MAX  = 19'd359999;
    localparam logic [VALUE_W-1:0] SPEED_MAX = 19'd9999;
    localparam logic [VALUE_W-1:0] TIME_ADJ  = 19'd59;

    // place weights of the four shown digits (hours:minutes or decimal)
    localparam int TIME_W  [NUM_DIG] = '{36000, 3600, 600, 60};
    localparam int SPEED_W [NUM_DIG] = '{1000, 100, 10, 1};

    localparam logic [7:0] DASH_SET   = 8'h08;
    localparam logic [7:0] DASH_REM   = 8'h10;
    localparam logic [7:0] MARK_HIGH  = 8'h80;
    localparam logic [7:0] ICON_BIT   = 8'h01;
    localparam logic [7:0] ICON_CLEAR = 8'hFE;

    // lcd addresses, first to fourth byte
    localparam logic [ADDR_W-1:0] ADDR_SET_TIME  [NUM_DIG] = '{6'd0, 6'd2, 6'd4, 6'd6};
    localparam logic [ADDR_W-1:0] ADDR_REM_TIME  [NUM_DIG] = '{6'd54, 6'd52, 6'd50, 6'd48};
    localparam logic [ADDR_W-1:0] ADDR_SET_SPEED [NUM_DIG] = '{6'd26, 6'd28, 6'd30, 6'd32};
    localparam logic [ADDR_W-1:0] ADDR_ACT_SPEED [NUM_DIG] = '{6'd46, 6'd44, 6'd42, 6'd40};

    typedef logic [3:0] bcd_t;
    typedef bcd_t [NUM_DIG-1:0] bcd_set_t;
    typedef logic [NUM_DIG-1:0][7:0] seg_set_t;
    typedef logic [NUM_DIG-1:0][ADDR_W-1:0] addr_set_t;

    // one item after saturation, as held in the input register
    typedef struct packed {
        logic [1:0]         op;
        logic [VALUE_W-1:0] value;
        logic               is_zero;
        logic               digits_blank;
        logic               time_in_use;
        logic               icon_off;
        logic               running;
    } item_t;

    function automatic logic [7:0] seg_low_left(input bcd_t d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h77;
            4'd1:    s = 8'h24;
            4'd2:    s = 8'h5d;
            4'd3:    s = 8'h6d;
            4'd4:    s = 8'h2e;
            4'd5:    s = 8'h6b;
            4'd6:    s = 8'h7b;
            4'd7:    s = 8'h25;
            4'd8:    s = 8'h7f;
            4'd9:    s = 8'h6f;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] seg_upper(input bcd_t d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'hee;
            4'd1:    s = 8'h24;
            4'd2:    s = 8'hba;
            4'd3:    s = 8'hb6;
            4'd4:    s = 8'h74;
            4'd5:    s = 8'hd6;
            4'd6:    s = 8'hde;
            4'd7:    s = 8'ha4;
            4'd8:    s = 8'hfe;
            4'd9:    s = 8'hf6;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] seg_low_right(input bcd_t d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'hee;
            4'd1:    s = 8'h48;
            4'd2:    s = 8'hba;
            4'd3:    s = 8'hda;
            4'd4:    s = 8'h5c;
            4'd5:    s = 8'hd6;
            4'd6:    s = 8'hf6;
            4'd7:    s = 8'h4a;
            4'd8:    s = 8'hfe;
            4'd9:    s = 8'hde;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

// ----- rtl/tssf_sat.sv -----
`timescale 1ns / 1ps
// tssf_sat: panel-dependent offset and saturation of the incoming value.
// Uses tssf_pkg.

module tssf_sat (
    input  logic [1:0]                   op,
    input  logic [tssf_pkg::VALUE_W-1:0] value,
    output logic [tssf_pkg::VALUE_W-1:0] value_sat,
    output logic                         is_zero
);

    logic [tssf_pkg::VALUE_W:0] sum;

    // remaining time rounds up to the next whole minute
    assign sum = {1'b0, value} + {1'b0, tssf_pkg::TIME_ADJ};

    always_comb begin
        case (op)
            tssf_pkg::PANEL_SET_TIME: begin
                value_sat = (value > tssf_pkg::TIME_MAX) ? tssf_pkg::TIME_MAX : value;
            end
            tssf_pkg::PANEL_REM_TIME: begin
                value_sat = (sum > {1'b0, tssf_pkg::TIME_MAX}) ? tssf_pkg::TIME_MAX
                                                               : sum[tssf_pkg::VALUE_W-1:0];
            end
            tssf_pkg::PANEL_SET_SPEED, tssf_pkg::PANEL_ACT_SPEED: begin
                value_sat = (value > tssf_pkg::SPEED_MAX) ? tssf_pkg::SPEED_MAX : value;
            end
            default: begin
                value_sat = '0;
            end
        endcase
    end

    assign is_zero = (value == '0);

endmodule

// ----- rtl/tssf_split.sv -----
`timescale 1ns / 1ps
// tssf_split: splits a saturated value into four decimal digits, either
// hh:mm from seconds or four plain decimal places. Uses tssf_pkg.

module tssf_split (
    input  logic [tssf_pkg::VALUE_W-1:0] value,
    input  logic                         is_time,
    output tssf_pkg::bcd_set_t           digits
);

    logic [tssf_pkg::VALUE_W-1:0] rem;
    logic [tssf_pkg::VALUE_W-1:0] mult;
    logic [tssf_pkg::VALUE_W-1:0] sub;
    tssf_pkg::bcd_t               dig;

    // four compare-and-subtract steps, each against the nine multiples of
    // its place weight in parallel; leftover seconds are dropped
    always_comb begin
        rem    = value;
        mult   = '0;
        sub    = '0;
        dig    = '0;
        digits = '0;
        for (int s = 0; s < tssf_pkg::NUM_DIG; s++) begin
            dig = '0;
            sub = '0;
            for (int k = 1; k <= 9; k++) begin
                mult = is_time ? tssf_pkg::VALUE_W'(k * tssf_pkg::TIME_W[s])
                               : tssf_pkg::VALUE_W'(k * tssf_pkg::SPEED_W[s]);
                if (rem >= mult) begin
                    dig = 4'(k);
                    sub = mult;
                end
            end
            digits[tssf_pkg::NUM_DIG-1-s] = dig;
            rem = rem - sub;
        end
    end

endmodule

// ----- rtl/tssf_encode.sv -----
`timescale 1ns / 1ps
// tssf_encode: digit tables, dashes, blanking, colon and icon bits and lcd
// addresses for the selected panel. Uses tssf_pkg.

module tssf_encode (
    input  tssf_pkg::item_t     item,
    input  tssf_pkg::bcd_set_t  digits,
    output tssf_pkg::seg_set_t  seg,
    output tssf_pkg::addr_set_t addr
);

    // digits[3] is the most significant, seg[0] is the first byte
    always_comb begin
        seg  = '0;
        addr = '0;
        case (item.op)
            tssf_pkg::PANEL_SET_TIME: begin
                for (int i = 0; i < tssf_pkg::NUM_DIG; i++) begin
                    if (item.digits_blank) begin
                        seg[i] = '0;
                    end else if (item.is_zero) begin
                        seg[i] = tssf_pkg::DASH_SET;
                    end else begin
                        seg[i] = tssf_pkg::seg_low_left(digits[tssf_pkg::NUM_DIG-1-i]);
                    end
                    addr[i] = tssf_pkg::ADDR_SET_TIME[i];
                end
                seg[1] = seg[1] | tssf_pkg::MARK_HIGH;
                seg[3] = seg[3] | tssf_pkg::MARK_HIGH;
            end
            tssf_pkg::PANEL_REM_TIME: begin
                for (int i = 0; i < tssf_pkg::NUM_DIG; i++) begin
                    seg[i]  = item.time_in_use
                              ? tssf_pkg::seg_upper(digits[tssf_pkg::NUM_DIG-1-i])
                              : tssf_pkg::DASH_REM;
                    addr[i] = tssf_pkg::ADDR_REM_TIME[i];
                end
                seg[1] = seg[1] | tssf_pkg::ICON_BIT;
                seg[3] = seg[3] | tssf_pkg::ICON_BIT;
                if (item.running && item.icon_off) begin
                    seg[1] = seg[1] & tssf_pkg::ICON_CLEAR;
                    seg[3] = seg[3] & tssf_pkg::ICON_CLEAR;
                end
            end
            tssf_pkg::PANEL_SET_SPEED: begin
                for (int i = 0; i < tssf_pkg::NUM_DIG; i++) begin
                    seg[i]  = item.digits_blank
                              ? 8'h00
                              : tssf_pkg::seg_low_right(digits[tssf_pkg::NUM_DIG-1-i]);
                    addr[i] = tssf_pkg::ADDR_SET_SPEED[i];
                end
                seg[3] = seg[3] | tssf_pkg::ICON_BIT;
            end
            tssf_pkg::PANEL_ACT_SPEED: begin
                for (int i = 0; i < tssf_pkg::NUM_DIG; i++) begin
                    seg[i]  = tssf_pkg::seg_upper(digits[tssf_pkg::NUM_DIG-1-i]);
                    addr[i] = tssf_pkg::ADDR_ACT_SPEED[i];
                end
                seg[0] = seg[0] | tssf_pkg::ICON_BIT;
                seg[2] = seg[2] | tssf_pkg::ICON_BIT;
                if (item.icon_off) begin
                    seg[0] = seg[0] & tssf_pkg::ICON_CLEAR;
                    seg[1] = seg[1] & tssf_pkg::ICON_CLEAR;
                    seg[2] = seg[2] & tssf_pkg::ICON_CLEAR;
                end
            end
            default: begin
                seg  = '0;
                addr = '0;
            end
        endcase
    end

endmodule

// ----- rtl/time_speed_seven_segment_formatter_top.sv -----
`timescale 1ns / 1ps
// time_speed_seven_segment_formatter_top: input register, digit split and
// encode, result register. Uses tssf_pkg, tssf_sat, tssf_split, tssf_encode.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | op, value, digits_blank, time_in_use, icon_off, running
//  m_      | out       | m_valid / m_ready  | seg_first..seg_fourth, addr_first..addr_fourth
//
// One beat per cycle sustained while m_ready stays high; a taken input beat is
// saturated into the input register, then passes the four-step digit split and
// table lookup into the result register.
// Reset clears both stage valid flags; payload registers are not reset.
// While m_ready is low the result holds and one further beat can wait in the
// input register; s_ready falls only when both stages are full.

module time_speed_seven_segment_formatter_top (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_op,
    input  logic [tssf_pkg::VALUE_W-1:0]  s_value,
    input  logic                          s_digits_blank,
    input  logic                          s_time_in_use,
    input  logic                          s_icon_off,
    input  logic                          s_running,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_seg_first,
    output logic [7:0]                    m_seg_second,
    output logic [7:0]                    m_seg_third,
    output logic [7:0]                    m_seg_fourth,
    output logic [tssf_pkg::ADDR_W-1:0]   m_addr_first,
    output logic [tssf_pkg::ADDR_W-1:0]   m_addr_second,
    output logic [tssf_pkg::ADDR_W-1:0]   m_addr_third,
    output logic [tssf_pkg::ADDR_W-1:0]   m_addr_fourth
);

    logic                         in_valid_reg;
    logic                         out_valid_reg;
    tssf_pkg::item_t              item_reg;
    tssf_pkg::item_t              item_next;
    tssf_pkg::seg_set_t           seg_reg;
    tssf_pkg::seg_set_t           seg_next;
    tssf_pkg::addr_set_t          addr_reg;
    tssf_pkg::addr_set_t          addr_next;
    tssf_pkg::bcd_set_t           digits;
    logic [tssf_pkg::VALUE_W-1:0] value_sat;
    logic                         value_zero;
    logic                         out_adv;
    logic                         is_time;

    tssf_sat u_sat (
        .op        (s_op),
        .value     (s_value),
        .value_sat (value_sat),
        .is_zero   (value_zero)
    );

    always_comb begin
        item_next.op           = s_op;
        item_next.value        = value_sat;
        item_next.is_zero      = value_zero;
        item_next.digits_blank = s_digits_blank;
        item_next.time_in_use  = s_time_in_use;
        item_next.icon_off     = s_icon_off;
        item_next.running      = s_running;
    end

    assign is_time = (item_reg.op == tssf_pkg::PANEL_SET_TIME) ||
                     (item_reg.op == tssf_pkg::PANEL_REM_TIME);

    tssf_split u_split (
        .value   (item_reg.value),
        .is_time (is_time),
        .digits  (digits)
    );

    tssf_encode u_encode (
        .item   (item_reg),
        .digits (digits),
        .seg    (seg_next),
        .addr   (addr_next)
    );

    assign out_adv = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || out_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_adv) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= item_next;
        end
        if (out_adv && in_valid_reg) begin
            seg_reg  <= seg_next;
            addr_reg <= addr_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_seg_first   = seg_reg[0];
    assign m_seg_second  = seg_reg[1];
    assign m_seg_third   = seg_reg[2];
    assign m_seg_fourth  = seg_reg[3];
    assign m_addr_first  = addr_reg[0];
    assign m_addr_second = addr_reg[1];
    assign m_addr_third  = addr_reg[2];
    assign m_addr_fourth = addr_reg[3];

endmodule

// ----- tb/time_speed_seven_segment_formatter_top_tb.sv -----
`timescale 1ns / 1ps
// Testbench for time_speed_seven_segment_formatter_top: directed panel cases, random beats,
// a gap-free burst and a long output stall, checked against an in-bench panel formatter.
// Depends on tssf_pkg (panel codes, widths) and the formatter RTL only.

module time_speed_seven_segment_formatter_top_tb;

    localparam int          CYCLE_LIMIT = 200000;
    localparam int unsigned SEC_LIMIT   = 359999;
    localparam int unsigned RPM_LIMIT   = 9999;
    localparam int unsigned REM_OFFSET  = 59;
    localparam int          GAP_PCT     = 18;
    localparam int          MAX_PRINTS  = 40;

    localparam logic [7:0] SET_DASH  = 8'h08;
    localparam logic [7:0] REM_DASH  = 8'h10;
    localparam logic [7:0] COLON_BIT = 8'h80;
    localparam logic [7:0] ICON_MASK = 8'h01;

    localparam logic [7:0] LCD_LOW_LEFT [10] =
        '{8'h77, 8'h24, 8'h5d, 8'h6d, 8'h2e, 8'h6b, 8'h7b, 8'h25, 8'h7f, 8'h6f};
    localparam logic [7:0] LCD_UPPER [10] =
        '{8'hee, 8'h24, 8'hba, 8'hb6, 8'h74, 8'hd6, 8'hde, 8'ha4, 8'hfe, 8'hf6};
    localparam logic [7:0] LCD_LOW_RIGHT [10] =
        '{8'hee, 8'h48, 8'hba, 8'hda, 8'h5c, 8'hd6, 8'hf6, 8'h4a, 8'hfe, 8'hde};

    typedef struct {
        logic [1:0]                   op;
        logic [tssf_pkg::VALUE_W-1:0] value;
        logic                         digits_blank;
        logic                         time_in_use;
        logic                         icon_off;
        logic                         running;
    } panel_beat_t;

    typedef struct {
        logic [7:0]                  seg  [4];
        logic [tssf_pkg::ADDR_W-1:0] addr [4];
    } panel_bytes_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                         s_valid        = 1'b0;
    logic                         s_ready;
    logic [1:0]                   s_op           = '0;
    logic [tssf_pkg::VALUE_W-1:0] s_value        = '0;
    logic                         s_digits_blank = 1'b0;
    logic                         s_time_in_use  = 1'b0;
    logic                         s_icon_off     = 1'b0;
    logic                         s_running      = 1'b0;

    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [7:0]                   m_seg_first, m_seg_second, m_seg_third, m_seg_fourth;
    logic [tssf_pkg::ADDR_W-1:0]  m_addr_first, m_addr_second, m_addr_third, m_addr_fourth;

    panel_bytes_t pending_panels [$];
    int           errors        = 0;
    int           results_seen  = 0;
    int           beats_sent    = 0;
    int           panel_beats [4] = '{0, 0, 0, 0};
    int           cycle_count   = 0;
    bit           no_gaps       = 1'b0;
    int           stall_request = 0;
    int           stall_left    = 0;

    time_speed_seven_segment_formatter_top DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_value        (s_value),
        .s_digits_blank (s_digits_blank),
        .s_time_in_use  (s_time_in_use),
        .s_icon_off     (s_icon_off),
        .s_running      (s_running),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_seg_first    (m_seg_first),
        .m_seg_second   (m_seg_second),
        .m_seg_third    (m_seg_third),
        .m_seg_fourth   (m_seg_fourth),
        .m_addr_first   (m_addr_first),
        .m_addr_second  (m_addr_second),
        .m_addr_third   (m_addr_third),
        .m_addr_fourth  (m_addr_fourth)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hh:mm digits of a second count
    function automatic void split_hhmm(input int unsigned secs, output int unsigned d [4]);
        int unsigned hrs;
        int unsigned mins;
        hrs  = secs / 3600;
        mins = (secs % 3600) / 60;
        d[0] = (hrs / 10) % 10;
        d[1] = hrs % 10;
        d[2] = (mins / 10) % 10;
        d[3] = mins % 10;
    endfunction

    function automatic void split_decimal(input int unsigned v, output int unsigned d [4]);
        d[0] = (v / 1000) % 10;
        d[1] = (v / 100) % 10;
        d[2] = (v / 10) % 10;
        d[3] = v % 10;
    endfunction

    function automatic panel_bytes_t format_panel(input panel_beat_t b);
        panel_bytes_t r;
        int unsigned  v;
        int unsigned  d [4];
        for (int i = 0; i < 4; i++) begin
            r.seg[i] = 8'h00;
        end
        case (b.op)
            tssf_pkg::PANEL_SET_TIME: begin
                v = (b.value > SEC_LIMIT) ? SEC_LIMIT : b.value;
                if (!b.digits_blank) begin
                    if (v != 0) begin
                        split_hhmm(v, d);
                        for (int i = 0; i < 4; i++) r.seg[i] = LCD_LOW_LEFT[d[i]];
                    end else begin
                        for (int i = 0; i < 4; i++) r.seg[i] = SET_DASH;
                    end
                end
                r.seg[1] |= COLON_BIT;
                r.seg[3] |= COLON_BIT;
                r.addr = '{6'd0, 6'd2, 6'd4, 6'd6};
            end
            tssf_pkg::PANEL_REM_TIME: begin
                v = b.value + REM_OFFSET;
                if (v > SEC_LIMIT) v = SEC_LIMIT;
                if (b.time_in_use) begin
                    split_hhmm(v, d);
                    for (int i = 0; i < 4; i++) r.seg[i] = LCD_UPPER[d[i]];
                end else begin
                    for (int i = 0; i < 4; i++) r.seg[i] = REM_DASH;
                end
                r.seg[1] |= ICON_MASK;
                r.seg[3] |= ICON_MASK;
                if (b.running && b.icon_off) begin
                    r.seg[1] &= ~ICON_MASK;
                    r.seg[3] &= ~ICON_MASK;
                end
                r.addr = '{6'd54, 6'd52, 6'd50, 6'd48};
            end
            tssf_pkg::PANEL_SET_SPEED: begin
                v = (b.value > RPM_LIMIT) ? RPM_LIMIT : b.value;
                if (!b.digits_blank) begin
                    split_decimal(v, d);
                    for (int i = 0; i < 4; i++) r.seg[i] = LCD_LOW_RIGHT[d[i]];
                end
                r.seg[3] |= ICON_MASK;
                r.addr = '{6'd26, 6'd28, 6'd30, 6'd32};
            end
            default: begin
                v = (b.value > RPM_LIMIT) ? RPM_LIMIT : b.value;
                split_decimal(v, d);
                for (int i = 0; i < 4; i++) r.seg[i] = LCD_UPPER[d[i]];
                r.seg[0] |= ICON_MASK;
                r.seg[2] |= ICON_MASK;
                // icon blink off clears the icon bits whether running or not
                if (b.icon_off) begin
                    for (int i = 0; i < 3; i++) r.seg[i] &= ~ICON_MASK;
                end
                r.addr = '{6'd46, 6'd44, 6'd42, 6'd40};
            end
        endcase
        return r;
    endfunction

    function automatic panel_beat_t mk_beat(input logic [1:0] op, input int unsigned value,
                                            input bit blank, input bit in_use,
                                            input bit icon_off, input bit running);
        panel_beat_t b;
        b.op           = op;
        b.value        = value[tssf_pkg::VALUE_W-1:0];
        b.digits_blank = blank;
        b.time_in_use  = in_use;
        b.icon_off     = icon_off;
        b.running      = running;
        return b;
    endfunction

    function automatic panel_beat_t random_beat();
        int unsigned edges [12] = '{0, 1, 59, 60, 3599, 3600, 9999, 10000,
                                   359940, 359999, 360000, 524287};
        int unsigned v;
        int          pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            v = $urandom_range(0, 524287);
        else if (pick < 6)
            v = $urandom_range(0, SEC_LIMIT);
        else if (pick < 8)
            v = $urandom_range(0, 10100);
        else if (pick == 8)
            v = edges[$urandom_range(0, 11)] + $urandom_range(0, 2);
        else
            v = $urandom_range(0, 200);
        if (v > 524287) v = 524287;
        return mk_beat(2'($urandom_range(0, 3)), v, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
    endfunction

    // one input beat; the expectation is queued at the accepting edge
    task automatic send_beat(input panel_beat_t b);
        if (!no_gaps) begin
            while ($urandom_range(0, 99) < GAP_PCT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid        <= 1'b1;
        s_op           <= b.op;
        s_value        <= b.value;
        s_digits_blank <= b.digits_blank;
        s_time_in_use  <= b.time_in_use;
        s_icon_off     <= b.icon_off;
        s_running      <= b.running;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        pending_panels.push_back(format_panel(b));
        beats_sent++;
        panel_beats[b.op]++;
    endtask

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        if (errors < MAX_PRINTS)
            $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
        errors++;
    endtask

    // result side: random back-pressure, plus a counted hold-off on request
    always @(posedge aclk) begin
        if (stall_request != 0) begin
            stall_left    = stall_request;
            stall_request = 0;
        end
        if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (no_gaps) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= GAP_PCT);
        end
    end

    always @(posedge aclk) begin : check_result
        panel_bytes_t                want;
        logic [7:0]                  got_seg  [4];
        logic [tssf_pkg::ADDR_W-1:0] got_addr [4];
        string                       names    [4];
        names = '{"first", "second", "third", "fourth"};
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            results_seen++;
            if (pending_panels.size() == 0) begin
                report_mismatch("unexpected beat", m_seg_first, 8'h00);
            end else begin
                want     = pending_panels.pop_front();
                got_seg  = '{m_seg_first, m_seg_second, m_seg_third, m_seg_fourth};
                got_addr = '{m_addr_first, m_addr_second, m_addr_third, m_addr_fourth};
                for (int i = 0; i < 4; i++) begin
                    if (got_seg[i] !== want.seg[i])
                        report_mismatch({"seg_", names[i]}, got_seg[i], want.seg[i]);
                    if (got_addr[i] !== want.addr[i])
                        report_mismatch({"addr_", names[i]}, {2'b00, got_addr[i]},
                                        {2'b00, want.addr[i]});
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_panels.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic test_set_time_panel();
        send_beat(mk_beat(tssf_pkg::PANEL_SET_TIME, 0, 0, 1, 0, 0));       // dashes
        send_beat(mk_beat(tssf_pkg::PANEL_SET_TIME, 0, 1, 0, 1, 1));       // blanked zero
        send_beat(mk_beat(tssf_pkg::PANEL_SET_TIME, 45296, 0, 0, 0, 0));
        send_beat(mk_beat(tssf_pkg::PANEL_SET_TIME, 45296, 1, 1, 1, 0));
        send_beat(mk_beat(tssf_pkg::PANEL_SET_TIME, SEC_LIMIT, 0, 1, 1, 1));
        send_beat(mk_beat(tssf_pkg::PANEL_SET_TIME, 524287, 0, 0, 0, 1));  // saturates
    endtask

    task automatic test_remaining_time_panel();
        send_beat(mk_beat(tssf_pkg::PANEL_REM_TIME, 0, 0, 1, 0, 0));
        send_beat(mk_beat(tssf_pkg::PANEL_REM_TIME, 1, 1, 1, 0, 1));
        send_beat(mk_beat(tssf_pkg::PANEL_REM_TIME, 359941, 0, 1, 1, 0));
        send_beat(mk_beat(tssf_pkg::PANEL_REM_TIME, 524287, 1, 1, 0, 0));
        send_beat(mk_beat(tssf_pkg::PANEL_REM_TIME, 7200, 0, 0, 0, 0));   // not in use
        send_beat(mk_beat(tssf_pkg::PANEL_REM_TIME, 7200, 0, 1, 1, 1));   // icons cleared
        send_beat(mk_beat(tssf_pkg::PANEL_REM_TIME, 7200, 0, 0, 1, 1));
    endtask

    task automatic test_set_speed_panel();
        send_beat(mk_beat(tssf_pkg::PANEL_SET_SPEED, 0, 0, 0, 0, 0));
        send_beat(mk_beat(tssf_pkg::PANEL_SET_SPEED, RPM_LIMIT, 0, 1, 1, 1));
        send_beat(mk_beat(tssf_pkg::PANEL_SET_SPEED, 10000, 0, 0, 1, 0));
        send_beat(mk_beat(tssf_pkg::PANEL_SET_SPEED, 524287, 0, 1, 0, 1));
        send_beat(mk_beat(tssf_pkg::PANEL_SET_SPEED, 4567, 1, 0, 0, 0));
    endtask

    task automatic test_actual_speed_panel();
        send_beat(mk_beat(tssf_pkg::PANEL_ACT_SPEED, 0, 1, 0, 0, 0));
        send_beat(mk_beat(tssf_pkg::PANEL_ACT_SPEED, 1234, 0, 1, 0, 1));
        send_beat(mk_beat(tssf_pkg::PANEL_ACT_SPEED, RPM_LIMIT, 1, 1, 0, 0));
        send_beat(mk_beat(tssf_pkg::PANEL_ACT_SPEED, 524287, 0, 0, 1, 0));
        send_beat(mk_beat(tssf_pkg::PANEL_ACT_SPEED, 8080, 0, 0, 1, 1));
    endtask

    task automatic test_random_mix(input int count);
        for (int i = 0; i < count; i++) send_beat(random_beat());
    endtask

    task automatic test_back_to_back(input int count);
        no_gaps = 1'b1;
        for (int i = 0; i < count; i++) send_beat(random_beat());
        no_gaps = 1'b0;
    endtask

    // receiver holds off while the sender keeps offering, so s_ready must drop
    task automatic test_output_stall(input int count);
        no_gaps       = 1'b1;
        stall_request = 300;
        for (int i = 0; i < count; i++) send_beat(random_beat());
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_set_time_panel();
        test_remaining_time_panel();
        test_set_speed_panel();
        test_actual_speed_panel();
        test_random_mix(440);
        test_back_to_back(60);
        test_output_stall(30);
        test_random_mix(20);

        s_valid <= 1'b0;
        while (pending_panels.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("sent %0d beats: set time %0d, remaining %0d, set speed %0d, actual speed %0d",
                 beats_sent, panel_beats[tssf_pkg::PANEL_SET_TIME],
                 panel_beats[tssf_pkg::PANEL_REM_TIME], panel_beats[tssf_pkg::PANEL_SET_SPEED],
                 panel_beats[tssf_pkg::PANEL_ACT_SPEED]);
        $display("checked %0d result beats with gaps, a gap-free burst and a 300-cycle stall",
                 results_seen);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
